// File: rtl/text_line_number_and_escape_core_defines.svh
// Assertion macros used by the checker file of the line formatter.
// Needs clk and rst_n in the scope where a macro is used.
`ifndef TEXT_LINE_NUMBER_AND_ESCAPE_CORE_DEFINES_SVH
`define TEXT_LINE_NUMBER_AND_ESCAPE_CORE_DEFINES_SVH

// same-cycle implication
`define TLNE_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define TLNE_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/tlne_pkg.sv
// Types, constants and character codes of the line formatter.
// No dependencies.
`default_nettype none
package tlne_pkg;

  localparam int NUMBER_DIGITS = 6;
  localparam int DIG_W  = (NUMBER_DIGITS > 1) ? $clog2(NUMBER_DIGITS) : 1;
  localparam int CNT_W  = $clog2(NUMBER_DIGITS + 5);
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);
  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;

  localparam logic [2:0] REG_NUMBER_MODE   = 3'd0;
  localparam logic [2:0] REG_SHOW_ENDS     = 3'd1;
  localparam logic [2:0] REG_SQUEEZE       = 3'd2;
  localparam logic [2:0] REG_SHOW_TABS     = 3'd3;
  localparam logic [2:0] REG_SHOW_NONPRINT = 3'd4;

  localparam logic [1:0] MODE_NONE = 2'd0;
  localparam logic [1:0] MODE_ALL  = 2'd1;

  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_DASH   = 8'h2D;
  localparam logic [7:0] CH_QMARK  = 8'h3F;
  localparam logic [7:0] CH_I      = 8'h49;
  localparam logic [7:0] CH_M      = 8'h4D;
  localparam logic [7:0] CH_CARET  = 8'h5E;
  localparam logic [6:0] CH_DEL    = 7'h7F;
  localparam logic [3:0] ZERO_HI   = 4'h3;
  localparam logic [6:0] CTRL_TOP  = 7'd32;
  localparam logic [6:0] CTRL_OFS  = 7'd64;

  typedef logic [NUMBER_DIGITS-1:0][3:0] bcd_t;

  typedef struct packed {
    logic [1:0] number_mode;
    logic       show_line_ends;
    logic       squeeze_empty;
    logic       show_tabs;
    logic       show_nonprinting;
  } cfg_t;

  typedef struct packed {
    logic       has_num;
    bcd_t       num;
    logic       is_nl;
    logic [7:0] data;
  } job_t;

endpackage
`default_nettype wire

// File: rtl/tlne_regs.sv
// Configuration registers behind the APB-style port.
// Depends on tlne_pkg.
`default_nettype none
module tlne_regs (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      psel,
  input  wire logic                      penable,
  input  wire logic                      pwrite,
  input  wire logic [tlne_pkg::ADDR_W-1:0] paddr,
  input  wire logic [tlne_pkg::DATA_W-1:0] pwdata,
  output logic      [tlne_pkg::DATA_W-1:0] prdata,
  output logic                           pready,
  output tlne_pkg::cfg_t                 cfg
);
  import tlne_pkg::*;

  cfg_t       cfg_r, cfg_nxt;
  logic [2:0] idx;
  logic       wr;

  assign idx    = paddr[4:2];
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr) begin
      case (idx)
        REG_NUMBER_MODE:   cfg_nxt.number_mode      = pwdata[1:0];
        REG_SHOW_ENDS:     cfg_nxt.show_line_ends   = pwdata[0];
        REG_SQUEEZE:       cfg_nxt.squeeze_empty    = pwdata[0];
        REG_SHOW_TABS:     cfg_nxt.show_tabs        = pwdata[0];
        REG_SHOW_NONPRINT: cfg_nxt.show_nonprinting = pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (idx)
      REG_NUMBER_MODE:   prdata[1:0] = cfg_r.number_mode;
      REG_SHOW_ENDS:     prdata[0]   = cfg_r.show_line_ends;
      REG_SQUEEZE:       prdata[0]   = cfg_r.squeeze_empty;
      REG_SHOW_TABS:     prdata[0]   = cfg_r.show_tabs;
      REG_SHOW_NONPRINT: prdata[0]   = cfg_r.show_nonprinting;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule
`default_nettype wire

// File: rtl/tlne_front.sv
// Front end: takes input beats, tracks line state and the BCD line number,
// and queues one job per beat that produces text. Depends on tlne_pkg.
`default_nettype none
module tlne_front (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           accept,
  input  wire logic           in_req_type,
  input  wire logic [7:0]     in_byte,
  input  wire tlne_pkg::cfg_t cfg,
  output logic                q_push,
  output tlne_pkg::job_t      q_job
);
  import tlne_pkg::*;

  localparam bcd_t NUM_ONE = bcd_t'(1);

  logic       als_r, als_nxt;
  logic [1:0] run_r, run_nxt;
  bcd_t       num_r, num_nxt;
  logic       emit, take_num, is_nl;

  function automatic bcd_t bcd_inc(input bcd_t v);
    bcd_t r;
    logic c;
    logic sat;
    r   = v;
    c   = 1'b1;
    sat = 1'b1;
    for (int i = 0; i < NUMBER_DIGITS; i++) begin
      sat = sat && (v[i] == 4'd9);
      if (c) begin
        if (v[i] == 4'd9) begin
          r[i] = 4'd0;
        end else begin
          r[i] = v[i] + 4'd1;
          c    = 1'b0;
        end
      end
    end
    return sat ? v : r;
  endfunction

  assign is_nl = (in_byte == CH_NL);

  always_comb begin
    als_nxt  = als_r;
    run_nxt  = run_r;
    emit     = 1'b0;
    take_num = 1'b0;
    if (accept) begin
      if (in_req_type) begin
        als_nxt = 1'b1;
      end else if (is_nl) begin
        if (als_r) begin
          run_nxt  = (run_r < 2'd2) ? run_r + 2'd1 : run_r;
          emit     = !(cfg.squeeze_empty && run_nxt > 2'd1);
          take_num = emit && (cfg.number_mode == MODE_ALL);
        end else begin
          emit    = 1'b1;
          als_nxt = 1'b1;
        end
      end else begin
        emit = 1'b1;
        if (als_r) begin
          run_nxt  = 2'd0;
          take_num = (cfg.number_mode != MODE_NONE);
          als_nxt  = 1'b0;
        end
      end
    end
    num_nxt = take_num ? bcd_inc(num_r) : num_r;
  end

  assign q_push        = emit;
  assign q_job.has_num = take_num;
  assign q_job.num     = num_r;
  assign q_job.is_nl   = is_nl;
  assign q_job.data    = in_byte;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      als_r <= 1'b1;
      run_r <= 2'd0;
      num_r <= NUM_ONE;
    end else begin
      als_r <= als_nxt;
      run_r <= run_nxt;
      num_r <= num_nxt;
    end
  end

endmodule
`default_nettype wire

// File: rtl/tlne_queue.sv
// Short job queue between front and back ends.
// Depends on tlne_pkg.
`default_nettype none
module tlne_queue (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           wr_en,
  input  wire tlne_pkg::job_t wr_job,
  input  wire logic           rd_en,
  output tlne_pkg::job_t      rd_job,
  output logic                q_full,
  output logic                q_empty
);
  import tlne_pkg::*;

  job_t              mem_r [QDEPTH];
  logic [QPTR_W-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              do_wr, do_rd;

  assign q_full  = (cnt_r == QCNT_W'(QDEPTH));
  assign q_empty = (cnt_r == '0);
  assign do_wr   = wr_en && !q_full;
  assign do_rd   = rd_en && !q_empty;
  assign rd_job  = mem_r[rp_r];

  always_comb begin
    wp_nxt  = do_wr ? wp_r + QPTR_W'(1) : wp_r;
    rp_nxt  = do_rd ? rp_r + QPTR_W'(1) : rp_r;
    cnt_nxt = cnt_r + QCNT_W'(do_wr) - QCNT_W'(do_rd);
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wp_r] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule
`default_nettype wire

// File: rtl/tlne_back.sv
// Back end: walks the head job (number, tab, escaped text) into the output
// register one byte per cycle while it is free or popped. Depends on tlne_pkg.
`default_nettype none
module tlne_back (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire tlne_pkg::cfg_t cfg,
  input  wire tlne_pkg::job_t job,
  input  wire logic           q_empty,
  output logic                q_pop,
  output logic                empty,
  input  wire logic           pop,
  output logic [7:0]          out_byte,
  output logic                out_last
);
  import tlne_pkg::*;

  typedef struct packed {
    logic [3:0][7:0] b;
    logic [2:0]      len;
  } exp_t;

  logic [CNT_W-1:0]  cnt_r, cnt_nxt, off, total, rel, dig_pos;
  logic              ov_r, ov_nxt;
  logic [7:0]        ob_r, ob_nxt;
  logic              ol_r, ol_nxt;
  logic              advance, last;
  logic [NUMBER_DIGITS-1:0] blank;
  exp_t              body;
  logic [7:0]        cur;
  logic [3:0]        dig;

  function automatic exp_t expand(input logic [7:0] c, input logic nl, input cfg_t f);
    exp_t       e;
    logic [7:0] t0, t1;
    logic [1:0] tl;
    logic [6:0] l;
    e.b = '0;
    l   = c[6:0];
    t0  = c;
    t1  = c;
    tl  = 2'd1;
    if (nl) begin
      if (f.show_line_ends) begin
        e.b[0] = CH_DOLLAR;
        e.b[1] = CH_NL;
        e.len  = 3'd2;
      end else begin
        e.b[0] = CH_NL;
        e.len  = 3'd1;
      end
    end else if (c == CH_TAB) begin
      if (f.show_tabs) begin
        e.b[0] = CH_CARET;
        e.b[1] = CH_I;
        e.len  = 3'd2;
      end else begin
        e.b[0] = CH_TAB;
        e.len  = 3'd1;
      end
    end else if (!f.show_nonprinting) begin
      e.b[0] = c;
      e.len  = 3'd1;
    end else begin
      if (l < CTRL_TOP) begin
        t0 = CH_CARET;
        t1 = {1'b0, l + CTRL_OFS};
        tl = 2'd2;
      end else if (l == CH_DEL) begin
        t0 = CH_CARET;
        t1 = CH_QMARK;
        tl = 2'd2;
      end else begin
        t0 = {1'b0, l};
      end
      if (c[7]) begin
        e.b[0] = CH_M;
        e.b[1] = CH_DASH;
        e.b[2] = t0;
        e.b[3] = t1;
        e.len  = 3'd2 + {1'b0, tl};
      end else begin
        e.b[0] = t0;
        e.b[1] = t1;
        e.len  = {1'b0, tl};
      end
    end
    return e;
  endfunction

  assign body    = expand(job.data, job.is_nl, cfg);
  assign off     = job.has_num ? CNT_W'(NUMBER_DIGITS + 1) : '0;
  assign total   = off + CNT_W'(body.len);
  assign last    = (cnt_r == total - CNT_W'(1));
  assign rel     = cnt_r - off;
  assign dig_pos = CNT_W'(NUMBER_DIGITS - 1) - cnt_r;
  assign dig     = job.num[dig_pos[DIG_W-1:0]];

  always_comb begin
    blank[0] = 1'b0;
    for (int i = NUMBER_DIGITS - 1; i > 0; i--) begin
      if (i == NUMBER_DIGITS - 1) begin
        blank[i] = (job.num[i] == 4'd0);
      end else begin
        blank[i] = (job.num[i] == 4'd0) && blank[i+1];
      end
    end
  end

  always_comb begin
    if (job.has_num && cnt_r < CNT_W'(NUMBER_DIGITS)) begin
      cur = blank[dig_pos[DIG_W-1:0]] ? CH_SPACE : {ZERO_HI, dig};
    end else if (job.has_num && cnt_r == CNT_W'(NUMBER_DIGITS)) begin
      cur = CH_TAB;
    end else begin
      cur = body.b[rel[1:0]];
    end
  end

  assign advance = !q_empty && (!ov_r || pop);
  assign q_pop   = advance && last;

  always_comb begin
    cnt_nxt = cnt_r;
    ov_nxt  = ov_r && !pop;
    ob_nxt  = ob_r;
    ol_nxt  = ol_r;
    if (advance) begin
      cnt_nxt = last ? '0 : cnt_r + CNT_W'(1);
      ov_nxt  = 1'b1;
      ob_nxt  = cur;
      ol_nxt  = last;
    end
  end

  assign empty    = !ov_r;
  assign out_byte = ob_r;
  assign out_last = ol_r;

  always_ff @(posedge clk) begin
    ob_r <= ob_nxt;
    ol_r <= ol_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      ov_r  <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      ov_r  <= ov_nxt;
    end
  end

endmodule
`default_nettype wire

// File: rtl/text_line_number_and_escape_core.sv
// Usage
//   Input queue port: push/full with in_req_type (0 data byte, 1 end of source)
//   and in_byte. Output queue port: empty/pop with out_byte and out_last, which
//   marks the final byte caused by one input beat. Beats that cause no text
//   (end of source, squeezed empty lines) produce nothing on the output.
//   Registers number_mode, show_line_ends, squeeze_empty, show_tabs and
//   show_nonprinting sit at byte addresses 0,4,8,12,16 of the APB-style port;
//   write them only while the block is idle.
//   An input beat's first output byte passes the job queue, then the output
//   register. The back end emits one byte per cycle while pop keeps the
//   output register free; a line number adds NUMBER_DIGITS+1 bytes and an
//   escape up to three more. A four-entry job queue lets input run ahead while
//   the back end expands. When pop stays low the output byte holds, the queue
//   fills and full rises. Reset clears the registers, sets line start and the
//   line number to 1, and empties the queue and output register.
// Depends on tlne_pkg, tlne_regs, tlne_front, tlne_queue, tlne_back.
`default_nettype none
module text_line_number_and_escape_core (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        push,
  output logic                             full,
  input  wire logic                        in_req_type,
  input  wire logic [7:0]                  in_byte,
  output logic                             empty,
  input  wire logic                        pop,
  output logic [7:0]                       out_byte,
  output logic                             out_last,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [tlne_pkg::ADDR_W-1:0] paddr,
  input  wire logic [tlne_pkg::DATA_W-1:0] pwdata,
  output logic      [tlne_pkg::DATA_W-1:0] prdata,
  output logic                             pready
);
  import tlne_pkg::*;

  cfg_t cfg;
  job_t f_job, b_job;
  logic f_push, q_full, q_empty, q_pop, accept;

  assign full   = q_full;
  assign accept = push && !q_full;

  tlne_regs u_regs (
    .clk, .rst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready, .cfg
  );

  tlne_front u_front (
    .clk, .rst_n, .accept, .in_req_type, .in_byte, .cfg,
    .q_push(f_push), .q_job(f_job)
  );

  tlne_queue u_queue (
    .clk, .rst_n, .wr_en(f_push), .wr_job(f_job), .rd_en(q_pop),
    .rd_job(b_job), .q_full, .q_empty
  );

  tlne_back u_back (
    .clk, .rst_n, .cfg, .job(b_job), .q_empty, .q_pop,
    .empty, .pop, .out_byte, .out_last
  );

endmodule
`default_nettype wire

// File: rtl/tlne_checker.sv
// Port-level checks for the line formatter, bound to the top level.
// Depends on text_line_number_and_escape_core_defines.svh.
`default_nettype none
`include "text_line_number_and_escape_core_defines.svh"
module tlne_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       full,
  input wire logic       empty,
  input wire logic       pop,
  input wire logic [7:0] out_byte,
  input wire logic       out_last
);

  `TLNE_ASSERT_IMP(a_reset_idle, !$past(rst_n), empty && !full, "not idle after reset")
  `TLNE_ASSERT_NXT(a_hold, !empty && !pop, !empty && $stable(out_byte) && $stable(out_last), "output beat changed while stalled")
  `TLNE_ASSERT_IMP(a_nl_last, !empty && out_byte == 8'h0A, out_last, "newline not last byte of its beat")

endmodule

bind text_line_number_and_escape_core tlne_checker u_tlne_checker (
  .clk, .rst_n, .full, .empty, .pop, .out_byte, .out_last
);
`default_nettype wire

// File: verif/text_line_number_and_escape_core_test.sv
// Self-checking testbench for the line number and escape formatter core.
// Drives byte and end-of-source beats, checks formatted output against a local predictor.
// Depends on tlne_pkg and text_line_number_and_escape_core.
`timescale 1ns / 1ps
module text_line_number_and_escape_core_test;
  import tlne_pkg::*;

  localparam int SETTLE_CYCLES  = 16;
  localparam int BACKLOG_CYCLES = 300;
  localparam int RAND_PHASES    = 6;
  localparam int RAND_BEATS     = 58;
  localparam int RUN_LIMIT_NS   = 4_000_000;
  localparam int NUM_MAX        = 10 ** NUMBER_DIGITS - 1;
  localparam logic [2:0] REG_PAST_END = 3'd5;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } text_beat_t;

  typedef struct packed {
    logic [31:0] mode;
    logic [31:0] line_ends;
    logic [31:0] squeeze;
    logic [31:0] tabs;
    logic [31:0] nonprint;
    logic [31:0] spare;
  } reg_words_t;

  // text holds up to four expected bytes, first byte most significant
  typedef struct packed {
    logic [1:0]  set;
    logic        req;
    logic [7:0]  data;
    logic        typed;
    logic [2:0]  n;
    logic [31:0] text;
  } dir_row_t;

  localparam reg_words_t DIR_SETTINGS [4] = '{
    '{32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0},
    '{32'd1, 32'd1, 32'd1, 32'd1, 32'd1, 32'd0},
    '{32'd2, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0},
    '{32'hFFFF_FFFF, 32'hFFFF_FFFE, 32'h8000_0000, 32'h0000_0002, 32'hFFFF_FFFE,
      32'hFFFF_FFFF}
  };

  localparam dir_row_t DIR_ROWS [23] = '{
    '{2'd0, 1'b0, 8'h61, 1'b1, 3'd1, 32'h0000_0061},
    '{2'd0, 1'b0, 8'h00, 1'b1, 3'd1, 32'h0000_0000},
    '{2'd0, 1'b0, 8'hFF, 1'b1, 3'd1, 32'h0000_00FF},
    '{2'd0, 1'b0, 8'h09, 1'b1, 3'd1, 32'h0000_0009},
    '{2'd0, 1'b0, 8'h0A, 1'b1, 3'd1, 32'h0000_000A},
    '{2'd0, 1'b1, 8'hFF, 1'b1, 3'd0, 32'h0000_0000},
    '{2'd1, 1'b0, 8'h0A, 1'b0, 3'd0, 32'h0000_0000},
    '{2'd1, 1'b0, 8'h0A, 1'b0, 3'd0, 32'h0000_0000},
    '{2'd1, 1'b0, 8'h09, 1'b0, 3'd0, 32'h0000_0000},
    '{2'd1, 1'b0, 8'hFF, 1'b1, 3'd4, 32'h4D2D_5E3F},  // M-^?
    '{2'd1, 1'b0, 8'h80, 1'b1, 3'd4, 32'h4D2D_5E40},  // M-^@
    '{2'd1, 1'b0, 8'h7F, 1'b1, 3'd2, 32'h0000_5E3F},  // ^?
    '{2'd1, 1'b0, 8'h1F, 1'b1, 3'd2, 32'h0000_5E5F},  // ^_
    '{2'd1, 1'b0, 8'hA0, 1'b1, 3'd3, 32'h004D_2D20},  // M-space
    '{2'd1, 1'b0, 8'h7E, 1'b1, 3'd1, 32'h0000_007E},
    '{2'd1, 1'b1, 8'h00, 1'b1, 3'd0, 32'h0000_0000},
    '{2'd1, 1'b0, 8'h0A, 1'b0, 3'd0, 32'h0000_0000},
    '{2'd2, 1'b0, 8'h0A, 1'b0, 3'd0, 32'h0000_0000},
    '{2'd2, 1'b0, 8'h78, 1'b0, 3'd0, 32'h0000_0000},
    '{2'd2, 1'b0, 8'h0A, 1'b0, 3'd0, 32'h0000_0000},
    '{2'd3, 1'b0, 8'h0A, 1'b0, 3'd0, 32'h0000_0000},
    '{2'd3, 1'b0, 8'h00, 1'b0, 3'd0, 32'h0000_0000},
    '{2'd3, 1'b0, 8'h0A, 1'b0, 3'd0, 32'h0000_0000}
  };

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              push = 1'b0;
  logic              in_req_type = 1'b0;
  logic [7:0]        in_byte = 8'd0;
  logic              pop = 1'b0;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic              full;
  logic              empty;
  logic [7:0]        out_byte;
  logic              out_last;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  text_line_number_and_escape_core dut (
    .clk, .rst_n, .push, .full, .in_req_type, .in_byte, .empty, .pop,
    .out_byte, .out_last, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // predictor state
  cfg_t        cfg = '0;
  logic        at_start = 1'b1;
  logic [1:0]  blank_run = 2'd0;
  int          line_no = 1;
  logic [7:0]  fmt_bytes [$];
  text_beat_t  expected_text [$];

  int          sent_beats = 0;
  int          mismatches = 0;
  int          stall_left = 0;
  logic        quiet = 1'b0;
  logic        rx_hold = 1'b0;
  event        backlog_go;

  function automatic int idle_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic void add_fmt(input logic [7:0] b);
    fmt_bytes.insert(fmt_bytes.size(), b);
  endfunction

  function automatic void emit_line_number();
    logic [7:0] digs [NUMBER_DIGITS];
    int v;
    v = line_no;
    for (int i = NUMBER_DIGITS - 1; i >= 0; i--) begin
      if (v == 0 && i != NUMBER_DIGITS - 1) begin
        digs[i] = CH_SPACE;
      end else begin
        digs[i] = {ZERO_HI, 4'(v % 10)};
        v = v / 10;
      end
    end
    for (int i = 0; i < NUMBER_DIGITS; i++) add_fmt(digs[i]);
    add_fmt(CH_TAB);
    if (line_no < NUM_MAX) line_no++;
  endfunction

  function automatic void format_beat(input logic req, input logic [7:0] c);
    logic [7:0] ch;
    ch = c;
    fmt_bytes.delete();
    if (req) begin
      at_start = 1'b1;
      return;
    end
    if (ch == CH_NL) begin
      if (at_start && blank_run < 2'd2) blank_run++;
      if (!at_start || !(cfg.squeeze_empty && blank_run > 2'd1)) begin
        if (at_start && cfg.number_mode == MODE_ALL) emit_line_number();
        if (cfg.show_line_ends) add_fmt(CH_DOLLAR);
        add_fmt(CH_NL);
      end
      at_start = 1'b1;
    end else begin
      if (at_start) begin
        blank_run = 2'd0;
        if (cfg.number_mode != MODE_NONE) emit_line_number();
        at_start = 1'b0;
      end
      if (ch == CH_TAB) begin
        if (cfg.show_tabs) begin
          add_fmt(CH_CARET);
          add_fmt(CH_I);
        end else begin
          add_fmt(CH_TAB);
        end
      end else if (!cfg.show_nonprinting) begin
        add_fmt(ch);
      end else begin
        if (ch[7]) begin
          add_fmt(CH_M);
          add_fmt(CH_DASH);
          ch[7] = 1'b0;
        end
        if (ch[6:0] < CTRL_TOP) begin
          add_fmt(CH_CARET);
          add_fmt({1'b0, 7'(ch[6:0] + CTRL_OFS)});
        end else if (ch[6:0] == CH_DEL) begin
          add_fmt(CH_CARET);
          add_fmt(CH_QMARK);
        end else begin
          add_fmt(ch);
        end
      end
    end
  endfunction

  function automatic logic [7:0] text_byte();
    int r;
    r = $urandom_range(0, 9);
    if (r < 4) return 8'($urandom_range(32, 126));
    if (r == 4) return CH_TAB;
    if (r == 5) return 8'($urandom_range(0, 31));
    if (r == 6) return {1'b0, CH_DEL};
    return 8'($urandom_range(128, 255));
  endfunction

  task automatic send_beat(input logic req, input logic [7:0] c, input logic typed = 1'b0,
                           input logic [2:0] n = 3'd0, input logic [31:0] text = 32'd0);
    int gap;
    text_beat_t tb;
    gap = idle_gap();
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push <= 1'b1;
    in_req_type <= req;
    in_byte <= c;
    do @(posedge clk); while (full);
    sent_beats++;
    format_beat(req, c);
    if (typed) begin
      fmt_bytes.delete();
      for (int k = int'(n) - 1; k >= 0; k--) add_fmt(text[8*k +: 8]);
    end
    foreach (fmt_bytes[k]) begin
      tb.ch = fmt_bytes[k];
      tb.last = (k == fmt_bytes.size() - 1);
      expected_text.insert(expected_text.size(), tb);
    end
  endtask

  task automatic drain_output();
    push <= 1'b0;
    while (expected_text.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // psel stays high between back-to-back writes; caller lowers it
  task automatic reg_write(input logic [ADDR_W-1:0] a, input logic [DATA_W-1:0] d);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= a;
    pwdata <= d;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
  endtask

  task automatic apply_settings(input reg_words_t w);
    drain_output();
    reg_write({REG_NUMBER_MODE, 2'b00}, w.mode);
    reg_write({REG_SHOW_ENDS, 2'b00}, w.line_ends);
    reg_write({REG_SQUEEZE, 2'b00}, w.squeeze);
    reg_write({REG_SHOW_TABS, 2'b00}, w.tabs);
    reg_write({REG_SHOW_NONPRINT, 2'b00}, w.nonprint);
    reg_write({REG_PAST_END, 2'b00}, w.spare);
    psel <= 1'b0;
    penable <= 1'b0;
    cfg.number_mode = w.mode[1:0];
    cfg.show_line_ends = w.line_ends[0];
    cfg.squeeze_empty = w.squeeze[0];
    cfg.show_tabs = w.tabs[0];
    cfg.show_nonprinting = w.nonprint[0];
    @(posedge clk);
  endtask

  always @(posedge clk) begin : rx_side
    text_beat_t want;
    if (rst_n && pop && !empty) begin
      if (expected_text.size() == 0) begin
        if (mismatches < 10)
          $display("unexpected output beat: byte %02h last %0d", out_byte, out_last);
        mismatches++;
      end else begin
        want = expected_text.pop_front();
        if (out_byte !== want.ch || out_last !== want.last) begin
          if (mismatches < 10)
            $display("output mismatch: byte exp %02h got %02h, last exp %0d got %0d",
                     want.ch, out_byte, want.last, out_last);
          mismatches++;
        end
      end
      stall_left = idle_gap();
    end
    if (!rst_n || rx_hold) begin
      pop <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      pop <= 1'b0;
    end else begin
      pop <= 1'b1;
    end
  end

  // long receiver hold-off so the input side backs up
  initial forever begin
    @(backlog_go);
    @(negedge clk);
    rx_hold = 1'b1;
    repeat (BACKLOG_CYCLES) @(negedge clk);
    rx_hold = 1'b0;
  end

  initial begin : stimulus
    reg_words_t w;
    dir_row_t row;
    logic [31:0] junk;
    int cur_set;
    int phase_end;
    int kind;
    int r;
    cur_set = -1;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (DIR_ROWS[i]) begin
      row = DIR_ROWS[i];
      if (int'(row.set) != cur_set) begin
        cur_set = int'(row.set);
        apply_settings(DIR_SETTINGS[cur_set]);
      end
      send_beat(row.req, row.data, row.typed, row.n, row.text);
    end

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      junk = ($urandom_range(0, 1) != 0) ? $urandom : 32'd0;
      case (ph)
        0: w = '{32'd1, 32'd1, 32'd1, 32'd1, 32'd1, $urandom};
        1: w = '{32'd0, 32'd0, 32'd0, 32'd0, 32'd0, $urandom};
        2: w = '{32'd2, 32'd1, 32'd1, 32'd1, 32'd1, $urandom};
        default: begin
          w.mode = {junk[31:2], 2'($urandom_range(0, 3))};
          w.line_ends = {junk[31:1], 1'($urandom_range(0, 1))};
          w.squeeze = {junk[31:1], 1'($urandom_range(0, 1))};
          w.tabs = {junk[31:1], 1'($urandom_range(0, 1))};
          w.nonprint = {junk[31:1], 1'($urandom_range(0, 1))};
          w.spare = $urandom;
        end
      endcase
      apply_settings(w);
      quiet = (ph == 3);
      if (ph == 2) -> backlog_go;
      phase_end = sent_beats + RAND_BEATS;
      while (sent_beats < phase_end) begin
        kind = $urandom_range(0, 9);
        if (kind < 2) begin
          repeat ($urandom_range(1, 4)) send_beat(1'b0, CH_NL);
        end else if (kind == 2) begin
          repeat ($urandom_range(1, 4)) send_beat(1'($urandom_range(0, 1)), 8'($urandom));
        end else begin
          repeat ($urandom_range(0, 8)) send_beat(1'b0, text_byte());
          r = $urandom_range(0, 9);
          if (r < 7) send_beat(1'b0, CH_NL);
          else if (r < 9) send_beat(1'b1, 8'($urandom));
        end
      end
    end

    quiet = 1'b0;
    drain_output();
    if (mismatches == 0 && expected_text.size() == 0) begin
      $display("text_line_number_and_escape_core regression: pass");
    end else begin
      $display("text_line_number_and_escape_core regression: fail");
    end
    $finish;
  end

  initial begin
    #(RUN_LIMIT_NS);
    $display("text_line_number_and_escape_core regression: fail");
    $finish;
  end

endmodule
